// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the event matcher RTL.
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expr must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/wtwem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwem_pkg
// Types and constants shared by the weekly time-window event matcher.
// ----------------------------------------------------------------------------
package wtwem_pkg;

	localparam int MIN_W      = 11;
	localparam int DAYS_W     = 7;
	localparam int DOW_W      = 3;
	localparam int FLAGS_W    = 19;
	localparam int IN_FLAGS_W = 20;
	localparam int CODE_W     = 8;
	localparam int IDX_IN_W   = 5;
	localparam int CNT_CFG_W  = 6;

	// Flag bit positions inside the 20-bit entry flag word
	localparam int FLG_RECV_ONLY   = 3;
	localparam int FLG_CM_ONLY     = 4;
	localparam int FLG_NONCM_ONLY  = 5;
	localparam int FLG_LISTED_ONLY = 8;
	localparam int FLG_END_EMPTY   = 15;
	localparam int FLG_EXIT_EMPTY  = 16;
	localparam int FLG_EXIT_DONE   = 17;
	localparam int FLG_ENABLE      = 19;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               enable;
		logic [FLAGS_W-1:0] flags;
		logic [DAYS_W-1:0]  days;
		logic [MIN_W-1:0]   win_start;
		logic [MIN_W-1:0]   win_end;
		logic [CODE_W-1:0]  code;
	} entry_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ----- rtl/wtwem_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwem_table
// Event table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wtwem_table #(
	parameter int NUM_EVENTS = 32,
	localparam int AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  wtwem_pkg::entry_t      wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output wtwem_pkg::entry_t      rd_data
);
	wtwem_pkg::entry_t mem_q [NUM_EVENTS];
	wtwem_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/wtwem_match_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwem_match_unit
// Shared compare unit: checks one table entry against the query day and time.
// ----------------------------------------------------------------------------
module wtwem_match_unit (
	input  wtwem_pkg::entry_t                 entry,
	input  logic [wtwem_pkg::DOW_W-1:0]       day,
	input  logic [wtwem_pkg::MIN_W-1:0]       now,
	output logic                              hit
);
	logic [wtwem_pkg::DAYS_W:0] days_ext;
	logic                       day_ok;
	logic                       after_start;
	logic                       before_end;
	logic                       in_window;

	always_comb begin
		// weekday seven has no mask bit and never matches
		days_ext    = {1'b0, entry.days};
		day_ok      = days_ext[day];
		after_start = (now >= entry.win_start);
		before_end  = (now < entry.win_end);
		// end at or before start wraps past midnight
		if (entry.win_end <= entry.win_start) begin
			in_window = after_start || before_end;
		end else begin
			in_window = after_start && before_end;
		end
		hit = entry.enable && day_ok && in_window;
	end

endmodule

// ----- rtl/weekly_time_window_event_matcher_top.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// weekly_time_window_event_matcher_top
// Scheduled event table with a sequential first-match scan per query.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// item in  | start, busy          | mode, entry_*, day_of_week, minute_of_day,
//          |                      | node_is_cm, node_is_listed, queue_empty
// result   | done (one cycle)     | matched, event_index, event_flags,
//          |                      | poll_allowed, end_event, exit_program, exit_code
// config   | cfg_we               | cfg_wdata (event_count)
//
// A write item's result strobes in the next cycle and busy stays low. A query
// holds busy from accept until its result, scanning N = min(event_count,
// NUM_EVENTS) entries and stopping early on a match; the single table read
// port feeding the shared compare unit, one entry per cycle, sets its pace.
// Reset clears the sequencer, the count register and the strobe; the table
// holds garbage until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module weekly_time_window_event_matcher_top #(
	parameter int NUM_EVENTS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  mode,
	input  logic [wtwem_pkg::IDX_IN_W-1:0]        entry_index,
	input  logic [wtwem_pkg::IN_FLAGS_W-1:0]      entry_flags,
	input  logic [wtwem_pkg::DAYS_W-1:0]          entry_days,
	input  logic [wtwem_pkg::MIN_W-1:0]           entry_start,
	input  logic [wtwem_pkg::MIN_W-1:0]           entry_end,
	input  logic [wtwem_pkg::CODE_W-1:0]          entry_exit_code,
	input  logic [wtwem_pkg::DOW_W-1:0]           day_of_week,
	input  logic [wtwem_pkg::MIN_W-1:0]           minute_of_day,
	input  logic                                  node_is_cm,
	input  logic                                  node_is_listed,
	input  logic                                  queue_empty,
	input  logic                                  cfg_we,
	input  logic [wtwem_pkg::CNT_CFG_W-1:0]       cfg_wdata,
	output logic                                  done,
	output logic                                  matched,
	output logic [wtwem_pkg::IDX_IN_W-1:0]        event_index,
	output logic [wtwem_pkg::FLAGS_W-1:0]         event_flags,
	output logic                                  poll_allowed,
	output logic                                  end_event,
	output logic                                  exit_program,
	output logic [wtwem_pkg::CODE_W-1:0]          exit_code
);
	localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int CNT_W = $clog2(NUM_EVENTS + 1);
	localparam int CMP_W = (CNT_W > wtwem_pkg::CNT_CFG_W) ? CNT_W : wtwem_pkg::CNT_CFG_W;
	localparam int XW    = (IDX_W > wtwem_pkg::IDX_IN_W) ? IDX_W : wtwem_pkg::IDX_IN_W;
	localparam int SW    = (CNT_W > wtwem_pkg::IDX_IN_W) ? CNT_W : wtwem_pkg::IDX_IN_W;

	wtwem_pkg::state_t state_q, state_d;

	logic [wtwem_pkg::CNT_CFG_W-1:0] event_count_q;
	logic [CNT_W-1:0]                rd_q;
	logic                            chk_v_q;
	logic [IDX_W-1:0]                chk_idx_q;

	logic [wtwem_pkg::DOW_W-1:0]     dow_q;
	logic [wtwem_pkg::MIN_W-1:0]     now_q;
	logic                            cm_q;
	logic                            listed_q;
	logic                            qempty_q;

	logic                            done_q;
	logic                            matched_q;
	logic [wtwem_pkg::IDX_IN_W-1:0]  event_index_q;
	logic [wtwem_pkg::FLAGS_W-1:0]   event_flags_q;
	logic                            poll_q;
	logic                            end_q;
	logic                            exit_q;
	logic [wtwem_pkg::CODE_W-1:0]    code_q;

	logic                            accept;
	logic                            wr_accept;
	logic                            q_accept;
	logic [CMP_W-1:0]                cnt_ext;
	logic [CNT_W-1:0]                lim;
	logic [SW-1:0]                   wr_idx_cmp;
	logic [XW-1:0]                   wr_idx_ext;
	logic                            wr_en;
	logic [IDX_W-1:0]                wr_addr;
	wtwem_pkg::entry_t               wr_entry;
	wtwem_pkg::entry_t               rd_entry;
	logic                            issue;
	logic                            finish;
	logic                            hit;
	logic                            win;
	logic [XW-1:0]                   hit_idx_ext;
	logic                            poll_d;
	logic                            end_d;
	logic                            exit_d;

	assign accept    = start && !busy;
	assign wr_accept = accept && (mode == wtwem_pkg::MODE_WRITE);
	assign q_accept  = accept && (mode == wtwem_pkg::MODE_QUERY);

	// Clamp the scan length to the table depth
	always_comb begin
		cnt_ext = CMP_W'(event_count_q);
		if (cnt_ext > CMP_W'(NUM_EVENTS)) begin
			lim = CNT_W'(NUM_EVENTS);
		end else begin
			lim = CNT_W'(cnt_ext);
		end
	end

	// Drop writes to slots past the table depth
	always_comb begin
		wr_idx_cmp = SW'(entry_index);
		wr_idx_ext = XW'(entry_index);
		wr_en      = wr_accept && (wr_idx_cmp < SW'(NUM_EVENTS));
		wr_addr    = wr_idx_ext[IDX_W-1:0];
		wr_entry.enable    = entry_flags[wtwem_pkg::FLG_ENABLE];
		wr_entry.flags     = entry_flags[wtwem_pkg::FLAGS_W-1:0];
		wr_entry.days      = entry_days;
		wr_entry.win_start = entry_start;
		wr_entry.win_end   = entry_end;
		wr_entry.code      = entry_exit_code;
	end

	wtwem_table #(
		.NUM_EVENTS (NUM_EVENTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_addr (rd_q[IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	wtwem_match_unit u_match (
		.entry (rd_entry),
		.day   (dow_q),
		.now   (now_q),
		.hit   (hit)
	);

	// Policy decode of the winning entry's flags
	always_comb begin
		win         = chk_v_q && hit;
		hit_idx_ext = XW'(chk_idx_q);
		poll_d = !(rd_entry.flags[wtwem_pkg::FLG_RECV_ONLY] ||
			(rd_entry.flags[wtwem_pkg::FLG_CM_ONLY] && !cm_q) ||
			(rd_entry.flags[wtwem_pkg::FLG_NONCM_ONLY] && cm_q) ||
			(rd_entry.flags[wtwem_pkg::FLG_LISTED_ONLY] && !listed_q));
		end_d  = rd_entry.flags[wtwem_pkg::FLG_END_EMPTY] && qempty_q;
		exit_d = !end_d && qempty_q &&
			(rd_entry.flags[wtwem_pkg::FLG_EXIT_EMPTY] ||
			rd_entry.flags[wtwem_pkg::FLG_EXIT_DONE]);
	end

	// Sequencer: next state and scan controls
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			wtwem_pkg::ST_IDLE: begin
				if (q_accept) begin
					state_d = wtwem_pkg::ST_SCAN;
				end
			end
			wtwem_pkg::ST_SCAN: begin
				issue = (rd_q < lim);
				// stop on a hit, or once the last issued entry has been checked
				finish = win || !issue;
				if (finish) begin
					state_d = wtwem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtwem_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != wtwem_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wtwem_pkg::ST_IDLE;
			event_count_q <= '0;
			rd_q          <= '0;
			chk_v_q       <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				event_count_q <= cfg_wdata;
			end
			if (q_accept) begin
				rd_q    <= '0;
				chk_v_q <= 1'b0;
			end else if (state_q == wtwem_pkg::ST_SCAN) begin
				chk_v_q <= issue;
				if (issue) begin
					rd_q <= rd_q + CNT_W'(1);
				end
			end
			done_q <= wr_accept || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (q_accept) begin
			dow_q    <= day_of_week;
			now_q    <= minute_of_day;
			cm_q     <= node_is_cm;
			listed_q <= node_is_listed;
			qempty_q <= queue_empty;
		end
		if (issue) begin
			chk_idx_q <= rd_q[IDX_W-1:0];
		end
		if (wr_accept || (finish && !win)) begin
			matched_q     <= 1'b0;
			event_index_q <= '0;
			event_flags_q <= '0;
			poll_q        <= 1'b1;
			end_q         <= 1'b0;
			exit_q        <= 1'b0;
			code_q        <= '0;
		end else if (finish) begin
			matched_q     <= 1'b1;
			event_index_q <= hit_idx_ext[wtwem_pkg::IDX_IN_W-1:0];
			event_flags_q <= rd_entry.flags;
			poll_q        <= poll_d;
			end_q         <= end_d;
			exit_q        <= exit_d;
			code_q        <= rd_entry.code;
		end
	end

	assign done         = done_q;
	assign matched      = matched_q;
	assign event_index  = event_index_q;
	assign event_flags  = event_flags_q;
	assign poll_allowed = poll_q;
	assign end_event    = end_q;
	assign exit_program = exit_q;
	assign exit_code    = code_q;

	`ASSERT_CLK(a_no_done_in_scan, (state_q == wtwem_pkg::ST_SCAN) |-> !done_q,
		"result strobe during scan")
	`ASSERT_CLK(a_chk_in_range,
		((state_q == wtwem_pkg::ST_SCAN) && chk_v_q) |-> (CNT_W'(chk_idx_q) < lim),
		"checked slot beyond scan limit")
	`ASSERT_CLK(a_rd_bound, (state_q == wtwem_pkg::ST_SCAN) |-> (rd_q <= lim),
		"read counter overran limit")
	`ASSERT_CLK(a_miss_clean, (done_q && !matched_q) |-> (poll_q && !end_q && !exit_q &&
		(event_flags_q == '0) && (code_q == '0)), "miss result not clean")
	`ASSERT_NEVER(a_end_xor_exit, done_q && end_q && exit_q, "end and exit both reported")

endmodule
